@@ design/ostw_pkg.sv @@
// ---------------------------------------------------------------------------
// ostw_pkg: shared types and constants of the offset sprite tile writer
// Item structs, register indexes, register reset values and transaction
// layout constants used by the lanes, the serialiser and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package ostw_pkg;

  localparam int TILE_BYTES = 8;
  localparam int TILE_W     = 8 * TILE_BYTES;
  localparam int NUM_LANES  = 4;

  // Column address bytes of a mirrored tile column
  localparam logic [7:0] COL_FIRST_BASE = 8'd120;
  localparam logic [7:0] COL_LAST_BASE  = 8'd127;

  localparam logic [3:0] ADDR_BYTES = 4'd8;
  localparam logic [3:0] DATA_BYTES = 4'd2;

  // Last data step of one tile: step 0 is the address transaction
  localparam logic [3:0] LAST_STEP = 4'(TILE_BYTES);

  typedef enum logic [7:0] {
    REG_CONTROL_PREFIX = 8'd0,
    REG_DATA_PREFIX    = 8'd1,
    REG_PAGE_CMD       = 8'd2,
    REG_COLUMN_CMD     = 8'd3
  } reg_index_t;

  localparam logic [7:0] CONTROL_PREFIX_RST = 8'd0;
  localparam logic [7:0] DATA_PREFIX_RST    = 8'd64;
  localparam logic [7:0] PAGE_CMD_RST       = 8'd34;
  localparam logic [7:0] COLUMN_CMD_RST     = 8'd33;

  typedef struct packed {
    logic              kind;
    logic [3:0]        tile_col;
    logic [2:0]        tile_row;
    logic [6:0]        pixel_x;
    logic [5:0]        pixel_y;
    logic [TILE_W-1:0] sprite_bits;
    logic [TILE_W-1:0] back_top_left;
    logic [TILE_W-1:0] back_top_right;
    logic [TILE_W-1:0] back_bottom_left;
    logic [TILE_W-1:0] back_bottom_right;
  } in_item_t;

  typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  byte_count;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] control_prefix;
    logic [7:0] data_prefix;
    logic [7:0] page_cmd;
    logic [7:0] column_cmd;
  } cfg_t;

  // Merged tiles of one item, ready for the serialiser
  typedef struct packed {
    logic                                kind;
    logic [4:0]                          tcol;
    logic [3:0]                          trow;
    logic [NUM_LANES-1:0][TILE_W-1:0]    tiles;
  } hold_t;

  typedef struct packed {
    logic emit;
    logic done;
  } ser_status_t;

endpackage

`default_nettype wire

@@ design/ostw_lane.sv @@
// ---------------------------------------------------------------------------
// ostw_lane: merge of the shifted sprite into one background tile
// One lane per tile of the 2x2 area; the lane position selects which part
// of the shifted sprite falls into its tile.
// ---------------------------------------------------------------------------
`default_nettype none

module ostw_lane (
  input  wire logic [ostw_pkg::TILE_W-1:0] sprite,
  input  wire logic [ostw_pkg::TILE_W-1:0] back,
  input  wire logic [2:0]                  offx,
  input  wire logic [2:0]                  offy,
  input  wire logic                        is_right,
  input  wire logic                        is_bottom,
  output logic      [ostw_pkg::TILE_W-1:0] merged
);

  always_comb begin
    logic [2:0] jj;
    logic [2:0] idx;
    logic       covered;
    logic [7:0] s;
    logic [7:0] part;
    for (int j = 0; j < ostw_pkg::TILE_BYTES; j++) begin
      jj = 3'(j);
      if (is_right) begin
        covered = (jj < offx);
        idx     = offx - jj - 3'd1;
      end else begin
        covered = (jj >= offx);
        idx     = 3'd7 - (jj - offx);
      end
      s = sprite[{idx, 3'b000} +: 8];
      // The lower tile takes the bits pushed out of the upper one.
      if (is_bottom) begin
        part = 8'(s >> (4'd8 - {1'b0, offy}));
      end else begin
        part = 8'(s << offy);
      end
      merged[j*8 +: 8] = back[j*8 +: 8] | (covered ? part : 8'h00);
    end
  end

endmodule

`default_nettype wire

@@ design/ostw_serializer.sv @@
// ---------------------------------------------------------------------------
// ostw_serializer: transaction sequencer and output register
// Walks the tiles of the held item, giving one address transaction and
// then the tile bytes from the highest down for each tile.
// ---------------------------------------------------------------------------
`default_nettype none

module ostw_serializer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ostw_pkg::cfg_t      cfg,
  input  wire ostw_pkg::hold_t     hold,
  input  wire logic                hold_valid,
  output ostw_pkg::ser_status_t    status,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ostw_pkg::out_item_t      out_data
);

  logic [1:0]          tile_r, tile_nxt;
  logic [3:0]          step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  ostw_pkg::out_item_t out_item_r, out_item_nxt;

  logic                        emit;
  logic                        final_tile;
  logic                        last;
  logic [4:0]                  col;
  logic [3:0]                  row;
  logic [7:0]                  col8;
  logic [2:0]                  byte_idx;
  logic [ostw_pkg::TILE_W-1:0] tile;

  assign emit       = hold_valid && (!out_valid_r || out_ready);
  assign final_tile = hold.kind ? (tile_r == 2'd3) : 1'b1;
  assign last       = final_tile && (step_r == ostw_pkg::LAST_STEP);
  assign col        = hold.tcol + {4'b0000, tile_r[0]};
  assign row        = hold.trow + {3'b000, tile_r[1]};
  assign col8       = {col, 3'b000};
  assign byte_idx   = 3'(ostw_pkg::LAST_STEP - step_r);
  assign tile       = hold.tiles[tile_r];

  assign status.emit = emit;
  assign status.done = emit && last;

  always_comb begin
    tile_nxt      = tile_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (step_r == 4'd0) begin
        out_item_nxt.payload = {ostw_pkg::COL_LAST_BASE - col8,
                                ostw_pkg::COL_FIRST_BASE - col8,
                                cfg.column_cmd, cfg.control_prefix,
                                {4'b0000, row + 4'd1}, {4'b0000, row},
                                cfg.page_cmd, cfg.control_prefix};
        out_item_nxt.byte_count  = ostw_pkg::ADDR_BYTES;
        out_item_nxt.last_of_run = 1'b0;
      end else begin
        out_item_nxt.payload     = {48'h0, tile[{byte_idx, 3'b000} +: 8], cfg.data_prefix};
        out_item_nxt.byte_count  = ostw_pkg::DATA_BYTES;
        out_item_nxt.last_of_run = last;
      end
      if (step_r == ostw_pkg::LAST_STEP) begin
        step_nxt = 4'd0;
        tile_nxt = last ? 2'd0 : tile_r + 2'd1;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_r      <= 2'd0;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      tile_r      <= tile_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

@@ design/offset_sprite_tile_writer.sv @@
// ---------------------------------------------------------------------------
// offset_sprite_tile_writer: sprite and tile writer for a page-mode display
// Four lanes merge the shifted sprite into the background tiles; the
// serialiser turns the held tiles into address and data transactions.
// ---------------------------------------------------------------------------
// An accepted item is registered in the hold register, then its first
// transaction in the output register. Throughput: one transaction per cycle
// unless out_ready stalls it: 9 per aligned tile and 36 per offset sprite.
// The next item is taken into the hold register as the last transaction
// of the current one is loaded into the output register. Synchronous
// active-low reset clears control state and loads the register defaults.
`default_nettype none

module offset_sprite_tile_writer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ostw_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ostw_pkg::out_item_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [7:0]           cfg_index,
  input  wire logic [7:0]           cfg_data
);

  ostw_pkg::cfg_t        cfg_r, cfg_nxt;
  ostw_pkg::hold_t       hold_r, hold_nxt;
  logic                  hold_valid_r, hold_valid_nxt;
  ostw_pkg::ser_status_t ser_stat;
  logic                  in_accept;

  logic [ostw_pkg::NUM_LANES-1:0][ostw_pkg::TILE_W-1:0] backs;
  logic [ostw_pkg::NUM_LANES-1:0][ostw_pkg::TILE_W-1:0] merged;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        ostw_pkg::REG_CONTROL_PREFIX: cfg_nxt.control_prefix = cfg_data;
        ostw_pkg::REG_DATA_PREFIX:    cfg_nxt.data_prefix    = cfg_data;
        ostw_pkg::REG_PAGE_CMD:       cfg_nxt.page_cmd       = cfg_data;
        ostw_pkg::REG_COLUMN_CMD:     cfg_nxt.column_cmd     = cfg_data;
        default: ;
      endcase
    end
  end

  assign backs[0] = in_data.back_top_left;
  assign backs[1] = in_data.back_top_right;
  assign backs[2] = in_data.back_bottom_left;
  assign backs[3] = in_data.back_bottom_right;

  for (genvar g = 0; g < ostw_pkg::NUM_LANES; g++) begin : g_lane
    ostw_lane u_lane (
      .sprite    (in_data.sprite_bits),
      .back      (backs[g]),
      .offx      (in_data.pixel_x[2:0]),
      .offy      (in_data.pixel_y[2:0]),
      .is_right  (1'(g % 2)),
      .is_bottom (1'(g / 2)),
      .merged    (merged[g])
    );
  end

  // The hold register frees up in the cycle its last transaction is sent.
  assign in_ready  = !hold_valid_r || ser_stat.done;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    if (in_accept) begin
      hold_valid_nxt = 1'b1;
      hold_nxt.kind  = in_data.kind;
      if (in_data.kind) begin
        hold_nxt.tcol  = {1'b0, in_data.pixel_x[6:3]};
        hold_nxt.trow  = {1'b0, in_data.pixel_y[5:3]};
        hold_nxt.tiles = merged;
      end else begin
        hold_nxt.tcol     = {1'b0, in_data.tile_col};
        hold_nxt.trow     = {1'b0, in_data.tile_row};
        hold_nxt.tiles    = merged;
        hold_nxt.tiles[0] = in_data.sprite_bits;
      end
    end else if (ser_stat.done) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control_prefix <= ostw_pkg::CONTROL_PREFIX_RST;
      cfg_r.data_prefix    <= ostw_pkg::DATA_PREFIX_RST;
      cfg_r.page_cmd       <= ostw_pkg::PAGE_CMD_RST;
      cfg_r.column_cmd     <= ostw_pkg::COLUMN_CMD_RST;
      hold_valid_r         <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  ostw_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .hold       (hold_r),
    .hold_valid (hold_valid_r),
    .status     (ser_stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // An item may only overwrite the hold register as the previous one ends.
  a_hold_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && hold_valid_r |-> ser_stat.done)
    else $error("item accepted over a busy hold register");

  // Transactions are only produced for a held item.
  a_emit_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ser_stat.emit |-> hold_valid_r)
    else $error("transaction produced without a held item");

  // An address transaction is always followed by data of the same tile.
  a_addr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_count == ostw_pkg::ADDR_BYTES |-> !out_data.last_of_run)
    else $error("address transaction flagged as last of run");

  // After the final transaction is sent with no new item offered, the hold register is free.
  a_free_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    ser_stat.done && !in_valid |=> !hold_valid_r)
    else $error("hold register still busy after its last transaction");

endmodule

`default_nettype wire
